// ===== rtl/mwc_pkg.sv =====
// shared widths and sequencer codes for the mass-weighted centroid block
package mwc_pkg;

  // field widths
  localparam int POS_W  = 32;
  localparam int MASS_W = 16;
  localparam int CEN_W  = 32;
  localparam int SEEN_W = 7;

  // accumulator widths: Q46.8 weighted sums, Q14.8 mass total
  localparam int WSUM_W = 54;
  localparam int MTOT_W = 22;
  localparam int PROD_W = POS_W + MASS_W + 1;

  // bus widths
  localparam int S_DATA_W = 3 * POS_W + MASS_W;
  localparam int M_DATA_W = 104;
  localparam int M_USER_W = 2;

  // divider step counter
  localparam int DCNT_W = 6;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_DLOAD  = 3'd2;
  localparam logic [2:0] S_DSTEP  = 3'd3;
  localparam logic [2:0] S_DSTORE = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [WSUM_W-1:0] wsum_t;
  typedef logic [CEN_W-1:0]         cen_t;

endpackage

// ===== rtl/mass_weighted_centroid_top.sv =====
// center of mass of a streamed molecule, one shared multiplier and one shared divider
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: pos_x, pos_y, pos_z, atom_mass;
//           |     |                               | tlast: last_atom
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: center_x/y/z, atoms_seen;
//           |     |                               | tuser: zero_mass, too_many
//
// an accepted atom within MAX_ATOMS holds s_axis_tready low while it passes the one shared 32x17
// multiplier, a product register and one accumulate per axis
// the last atom then runs each axis through the shared restoring divider (one quotient bit
// per cycle over 54 bits) before the result is handed to the output
// register; a zero mass total skips the divider
// the output register lets non-last atoms be taken while a result waits; a new result
// waits in the sequencer until m_axis_tready frees the output register
// rst is synchronous and clears the sequencer, the accumulators and m_axis_tvalid
module mass_weighted_centroid_top #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], atom_mass [111:96]
  input  logic [mwc_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // last_atom
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // center_x [31:0], center_y [63:32], center_z [95:64], atoms_seen [102:96], zero [103]
  output logic [mwc_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // zero_mass [0], too_many [1]
  output logic [mwc_pkg::M_USER_W-1:0]    m_axis_tuser
);
  import mwc_pkg::*;

  localparam int CNT_W = $clog2(MAX_ATOMS + 1);
  localparam int CXT_W = (CNT_W > SEEN_W) ? CNT_W : SEEN_W;

  // sequencer
  logic [2:0]        state;
  logic [1:0]        step;
  logic [1:0]        axis;
  logic [DCNT_W-1:0] bitcnt;

  // latched atom
  pos_t              pos [0:2];
  logic [MASS_W-1:0] mass_in;
  logic              last_in;

  // accumulators
  wsum_t             wsum [0:2];
  logic [MTOT_W-1:0] mtot;
  logic [CNT_W-1:0]  count;
  logic              ovf;

  // shared multiplier output register
  logic signed [PROD_W-1:0] prod;

  // divider registers
  logic              neg;
  logic [WSUM_W-1:0] num;
  logic [MTOT_W-1:0] rem;

  // staged result
  cen_t              cen [0:2];
  logic              zero_r;

  // combinational helpers
  logic [1:0]           acc_idx;
  logic [1:0]           sel_idx;
  pos_t                 pos_sel;
  wsum_t                wsum_sel;
  logic signed [WSUM_W:0] acc_sum;
  wsum_t                acc_sat;
  logic [MTOT_W:0]      mtot_sum;
  logic [MTOT_W-1:0]    mtot_sat;
  logic [WSUM_W-1:0]    mag;
  logic [MTOT_W:0]      rem_sh;
  logic                 rem_ge;
  logic [WSUM_W-1:0]    q_sat;
  cen_t                 q_out;
  logic                 full;
  logic [CXT_W-1:0]     cnt_ext;
  logic [SEEN_W-1:0]    seen;
  logic                 out_free;
  logic                 put_go;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign put_go        = (state == S_PUT) && out_free;
  assign full          = (count >= CNT_W'(MAX_ATOMS));
  assign acc_idx       = step - 2'd1;
  assign sel_idx       = (state == S_MAC) ? acc_idx : axis;

  // operand selection for the shared units
  always_comb begin
    unique case (step)
      2'd0:    pos_sel = pos[0];
      2'd1:    pos_sel = pos[1];
      default: pos_sel = pos[2];
    endcase
    unique case (sel_idx)
      2'd0:    wsum_sel = wsum[0];
      2'd1:    wsum_sel = wsum[1];
      default: wsum_sel = wsum[2];
    endcase
  end

  // saturating accumulate of one product
  always_comb begin
    acc_sum = (WSUM_W+1)'(wsum_sel) + (WSUM_W+1)'(prod);
    if (acc_sum[WSUM_W] != acc_sum[WSUM_W-1]) begin
      acc_sat = acc_sum[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[WSUM_W-1:0];
    end
    mtot_sum = {1'b0, mtot} + (MTOT_W+1)'(mass_in);
    mtot_sat = mtot_sum[MTOT_W] ? {MTOT_W{1'b1}} : mtot_sum[MTOT_W-1:0];
  end

  // divider operand, step and rounding saturation
  always_comb begin
    mag    = wsum_sel[WSUM_W-1] ? (WSUM_W)'(-wsum_sel) : wsum_sel;
    rem_sh = {rem, num[WSUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, mtot});
    if (neg) begin
      q_sat = (num > WSUM_W'(64'h8000_0000)) ? WSUM_W'(64'h8000_0000) : num;
      q_out = CEN_W'(WSUM_W'(0) - q_sat);
    end else begin
      q_sat = (num > WSUM_W'(64'h7FFF_FFFF)) ? WSUM_W'(64'h7FFF_FFFF) : num;
      q_out = q_sat[CEN_W-1:0];
    end
  end

  // atom count clamped to the field range
  assign cnt_ext = CXT_W'(count);
  assign seen    = (cnt_ext > CXT_W'(127)) ? SEEN_W'(127) : cnt_ext[SEEN_W-1:0];

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= 2'd0;
      axis          <= 2'd0;
      bitcnt        <= '0;
      wsum[0]       <= '0;
      wsum[1]       <= '0;
      wsum[2]       <= '0;
      mtot          <= '0;
      count         <= '0;
      ovf           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // output register release
      if (m_axis_tvalid && m_axis_tready && !put_go) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        // take an atom request
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pos[0]  <= s_axis_tdata[POS_W-1:0];
            pos[1]  <= s_axis_tdata[2*POS_W-1:POS_W];
            pos[2]  <= s_axis_tdata[3*POS_W-1:2*POS_W];
            mass_in <= s_axis_tdata[S_DATA_W-1:3*POS_W];
            last_in <= s_axis_tlast;
            step    <= 2'd0;
            axis    <= 2'd0;
            if (full) begin
              ovf <= 1'b1;
              if (s_axis_tlast) begin
                if (mtot == '0) begin
                  cen[0] <= '0;
                  cen[1] <= '0;
                  cen[2] <= '0;
                  zero_r <= 1'b1;
                  state  <= S_PUT;
                end else begin
                  zero_r <= 1'b0;
                  state  <= S_DLOAD;
                end
              end
            end else begin
              state <= S_MAC;
            end
          end
        end

        // multiply one axis while accumulating the previous one
        S_MAC: begin
          if (step != 2'd3) begin
            prod <= PROD_W'(pos_sel * $signed({1'b0, mass_in}));
          end
          if (step == 2'd0) begin
            mtot  <= mtot_sat;
            count <= count + CNT_W'(1);
          end else begin
            wsum[acc_idx] <= acc_sat;
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            if (!last_in) begin
              state <= S_IDLE;
            end else if (mtot == '0) begin
              cen[0] <= '0;
              cen[1] <= '0;
              cen[2] <= '0;
              zero_r <= 1'b1;
              state  <= S_PUT;
            end else begin
              zero_r <= 1'b0;
              state  <= S_DLOAD;
            end
          end
        end

        // rounded magnitude into the divider
        S_DLOAD: begin
          neg    <= wsum_sel[WSUM_W-1];
          num    <= mag + WSUM_W'(mtot >> 1);
          rem    <= '0;
          bitcnt <= '0;
          state  <= S_DSTEP;
        end

        // one restoring quotient bit
        S_DSTEP: begin
          rem    <= rem_ge ? MTOT_W'(rem_sh - {1'b0, mtot}) : rem_sh[MTOT_W-1:0];
          num    <= {num[WSUM_W-2:0], rem_ge};
          bitcnt <= bitcnt + DCNT_W'(1);
          if (bitcnt == DCNT_W'(WSUM_W - 1)) begin
            state <= S_DSTORE;
          end
        end

        // saturate and sign the quotient
        S_DSTORE: begin
          cen[axis] <= q_out;
          if (axis == 2'd2) begin
            state <= S_PUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DLOAD;
          end
        end

        // hand the result to the output register and clear for the next molecule
        S_PUT: begin
          if (out_free) begin
            m_axis_tdata  <= {zero_r & 1'b0, seen, cen[2], cen[1], cen[0]};
            m_axis_tuser  <= {ovf, zero_r};
            m_axis_tvalid <= 1'b1;
            wsum[0]       <= '0;
            wsum[1]       <= '0;
            wsum[2]       <= '0;
            mtot          <= '0;
            count         <= '0;
            ovf           <= 1'b0;
            axis          <= 2'd0;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/mwc_centroid_checker.sv =====
// checker for the mass-weighted centroid block: predicts each center of mass and compares it
`timescale 1ns / 100ps

module mwc_centroid_checker #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // pos_x, pos_y, pos_z, atom_mass
  input  logic [mwc_pkg::S_DATA_W-1:0] s_axis_tdata,
  // last_atom
  input  logic                         s_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // center_x, center_y, center_z, atoms_seen, zero pad
  input  logic [mwc_pkg::M_DATA_W-1:0] m_axis_tdata,
  // zero_mass, too_many
  input  logic [mwc_pkg::M_USER_W-1:0] m_axis_tuser,
  output int                           mismatches,
  output int                           pending,
  output int                           centers_checked
);
  import mwc_pkg::*;

  typedef struct packed {
    cen_t              cx;
    cen_t              cy;
    cen_t              cz;
    logic [SEEN_W-1:0] seen;
    logic              zero_mass;
    logic              too_many;
  } center_t;

  localparam longint WSUM_HI = (longint'(1) <<< (WSUM_W - 1)) - 1;
  localparam longint WSUM_LO = -WSUM_HI - 1;
  localparam longint MTOT_HI = (longint'(1) <<< MTOT_W) - 1;
  localparam longint NEG_CAP = 64'sh8000_0000;
  localparam longint POS_CAP = 64'sh7FFF_FFFF;

  // running molecule state
  longint  wsum_x = 0;
  longint  wsum_y = 0;
  longint  wsum_z = 0;
  longint  mass_sum = 0;
  int      atoms_held = 0;
  bit      past_limit = 1'b0;
  center_t centers_due[$];
  int      bad_count = 0;
  int      checked = 0;

  // weighted sum update with saturation at the accumulator limits
  function automatic longint mac_sat(longint acc, pos_t pos, logic [MASS_W-1:0] m);
    longint r;
    r = acc + longint'(pos) * longint'(m);
    if (r > WSUM_HI) r = WSUM_HI;
    if (r < WSUM_LO) r = WSUM_LO;
    return r;
  endfunction

  // quotient rounded to nearest, ties away from zero, clamped to 32 bit signed
  function automatic cen_t round_div(longint sum, longint total);
    longint mag;
    longint q;
    bit     neg;
    neg = sum < 0;
    mag = neg ? -sum : sum;
    q = (mag + total / 2) / total;
    if (neg) begin
      if (q > NEG_CAP) q = NEG_CAP;
      return cen_t'(-q);
    end
    if (q > POS_CAP) q = POS_CAP;
    return cen_t'(q);
  endfunction

  // fold one accepted atom into the molecule, queue a center on the last one
  task automatic take_atom();
    pos_t             px;
    pos_t             py;
    pos_t             pz;
    logic [MASS_W-1:0] m;
    center_t          c;
    px = s_axis_tdata[POS_W-1:0];
    py = s_axis_tdata[2*POS_W-1:POS_W];
    pz = s_axis_tdata[3*POS_W-1:2*POS_W];
    m  = s_axis_tdata[3*POS_W +: MASS_W];
    if (atoms_held >= MAX_ATOMS) begin
      past_limit = 1'b1;
    end else begin
      wsum_x = mac_sat(wsum_x, px, m);
      wsum_y = mac_sat(wsum_y, py, m);
      wsum_z = mac_sat(wsum_z, pz, m);
      mass_sum += longint'(m);
      if (mass_sum > MTOT_HI) mass_sum = MTOT_HI;
      atoms_held++;
    end
    if (s_axis_tlast) begin
      if (mass_sum == 0) begin
        c.cx = '0;
        c.cy = '0;
        c.cz = '0;
        c.zero_mass = 1'b1;
      end else begin
        c.cx = round_div(wsum_x, mass_sum);
        c.cy = round_div(wsum_y, mass_sum);
        c.cz = round_div(wsum_z, mass_sum);
        c.zero_mass = 1'b0;
      end
      c.seen = (atoms_held > 127) ? SEEN_W'(127) : SEEN_W'(atoms_held);
      c.too_many = past_limit;
      centers_due.push_back(c);
      wsum_x = 0;
      wsum_y = 0;
      wsum_z = 0;
      mass_sum = 0;
      atoms_held = 0;
      past_limit = 1'b0;
    end
  endtask

  // compare one delivered center with the oldest prediction
  task automatic check_center();
    center_t got;
    center_t want;
    got.cx = m_axis_tdata[CEN_W-1:0];
    got.cy = m_axis_tdata[2*CEN_W-1:CEN_W];
    got.cz = m_axis_tdata[3*CEN_W-1:2*CEN_W];
    got.seen = m_axis_tdata[3*CEN_W +: SEEN_W];
    got.zero_mass = m_axis_tuser[0];
    got.too_many = m_axis_tuser[1];
    checked++;
    if (centers_due.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("[%0t] unexpected center x=%0d y=%0d z=%0d seen=%0d zero=%0b over=%0b",
                 $realtime, $signed(got.cx), $signed(got.cy), $signed(got.cz), got.seen,
                 got.zero_mass, got.too_many);
    end else begin
      want = centers_due.pop_front();
      if (got !== want) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("[%0t] center mismatch, expected x=%0d y=%0d z=%0d seen=%0d zero=%0b over=%0b",
                   $realtime, $signed(want.cx), $signed(want.cy), $signed(want.cz), want.seen,
                   want.zero_mass, want.too_many);
          $display("          actual   x=%0d y=%0d z=%0d seen=%0d zero=%0b over=%0b",
                   $signed(got.cx), $signed(got.cy), $signed(got.cz), got.seen,
                   got.zero_mass, got.too_many);
        end
      end
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      centers_due.delete();
      wsum_x = 0;
      wsum_y = 0;
      wsum_z = 0;
      mass_sum = 0;
      atoms_held = 0;
      past_limit = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_atom();
      if (m_axis_tvalid && m_axis_tready) check_center();
    end
    mismatches <= bad_count;
    pending <= centers_due.size();
    centers_checked <= checked;
  end

endmodule

// ===== tb/sv/tb_mass_weighted_centroid_top.sv =====
// testbench top for the mass-weighted centroid block: stimulus, output stalls and verdict
`timescale 1ns / 100ps

module tb_mass_weighted_centroid_top;
  import mwc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], atom_mass [111:96]
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  // last_atom
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // center_x [31:0], center_y [63:32], center_z [95:64], atoms_seen [102:96], zero [103]
  logic [M_DATA_W-1:0]   m_axis_tdata;
  // zero_mass [0], too_many [1]
  logic [M_USER_W-1:0]   m_axis_tuser;

  int   mismatches;
  int   pending;
  int   centers_checked;
  bit   calm = 1'b0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  bit   paused = 1'b0;
  int   rx_stall = 0;
  bit [6:0] rx_cycle = '0;
  int   atoms_sent = 0;
  int   molecules_sent = 0;

  mass_weighted_centroid_top #(.MAX_ATOMS(64)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mwc_centroid_checker #(.MAX_ATOMS(64)) centroid_chk (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatches      (mismatches),
    .pending         (pending),
    .centers_checked (centers_checked)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  // output side: stall bursts, quiet stretches, none at the end
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle == '0) rx_quiet <= ($urandom_range(0, 3) == 0);
    if (calm) begin
      rx_stall <= 0;
      m_axis_tready <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!rst && !rx_quiet && $urandom_range(0, 4) == 0) begin
      rx_stall <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one atom request, with an optional idle burst ahead of it
  task automatic send_atom(pos_t x, pos_t y, pos_t z, logic [MASS_W-1:0] m, bit last);
    if (!calm && !tx_quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {m, z, y, x};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    atoms_sent++;
  endtask

  // coordinate near a molecule center, or anywhere
  function automatic pos_t pick_coord(pos_t center, bit spread);
    pos_t off;
    if (spread) return pos_t'($urandom);
    off = pos_t'($urandom_range(0, 8191));
    return center + off - 32'sd4096;
  endfunction

  // element masses in Q8.8, plus the extremes and anything else
  function automatic logic [MASS_W-1:0] pick_mass();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 16'd258;
      3: return 16'd3075;
      4: return 16'd3586;
      5: return 16'd4096;
      6: return 16'd8209;
      7: return 16'd7929;
      default: return MASS_W'($urandom);
    endcase
  endfunction

  task automatic send_molecule(int n, bit massless);
    pos_t cx;
    pos_t cy;
    pos_t cz;
    bit   spread;
    cx = pos_t'($urandom);
    cy = pos_t'($urandom);
    cz = pos_t'($urandom);
    spread = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      send_atom(pick_coord(cx, spread), pick_coord(cy, spread), pick_coord(cz, spread),
                massless ? '0 : pick_mass(), i == n - 1);
    molecules_sent++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single atoms at the coordinate and mass extremes
    send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF, 1'b1);
    send_atom(32'sd1, -32'sd1, 32'h8000_0000, 16'h0001, 1'b1);
    // zero mass total, one atom and two atoms
    send_atom(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    send_atom(32'sd5, -32'sd5, 32'sd7, 16'h0000, 1'b0);
    send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'sd9, 16'h0000, 1'b1);
    // exact halves round away from zero
    send_atom(32'sd1, -32'sd1, 32'sd3, 16'h0001, 1'b0);
    send_atom(32'sd2, -32'sd2, 32'sd0, 16'h0001, 1'b1);
    // fractions below a half, negative result near zero
    send_atom(32'sd0, 32'sd0, 32'sd0, 16'h0002, 1'b0);
    send_atom(32'sd1, -32'sd1, 32'h7FFF_FFFF, 16'h0001, 1'b1);
    // heavy atoms at opposite extremes, then a light one
    send_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_atom(32'h0123_4567, 32'hFEDC_BA98, 32'h5555_AAAA, 16'h0100, 1'b1);
    // massless atom followed by one of mass 128.0
    send_atom(32'sd5, 32'sd5, 32'sd5, 16'h0000, 1'b0);
    send_atom(-32'sd7, 32'sd9, 32'sd11, 16'h8000, 1'b1);

    // groups past the atom limit and exactly at it
    send_molecule(66, 1'b0);
    send_molecule(64, 1'b0);

    // random molecules with some noise; the tail runs without idling
    while (atoms_sent < 770) begin
      calm <= (atoms_sent >= 670);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (!paused && atoms_sent >= 400) begin
        // hold off until every center so far has come out
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        paused = 1'b1;
      end
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(1, 8))
             send_atom(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom), MASS_W'($urandom),
                       $urandom_range(0, 7) == 0);
        1: send_molecule($urandom_range(1, 5), 1'b1);
        2: send_molecule($urandom_range(62, 70), 1'b0);
        3: send_molecule(1, 1'b0);
        default: send_molecule($urandom_range(2, 12), 1'b0);
      endcase
    end
    send_molecule(1, 1'b0);

    // drain, then allow a divider pass of slack
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);

    $display("sent %0d atoms in %0d random molecules plus directed groups; %0d centers checked",
             atoms_sent, molecules_sent, centers_checked);
    $display("run mixed stalls on both sides, zero-mass and over-limit molecules, and noise");
    if (mismatches == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mwc_pkg.sv
rtl/mass_weighted_centroid_top.sv
tb/sv/mwc_centroid_checker.sv
tb/sv/tb_mass_weighted_centroid_top.sv
